### sv/tps_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tps_pkg
// Shared types, codes and defaults of the tick process scheduler.
// ---------------------------------------------------------------------------
package tps_pkg;

  localparam int DEF_NUM_ENTRIES = 8;
  localparam int SLEEP_W         = 16;
  localparam int SLICE_W         = 8;
  localparam int OUT_IDX_W       = 3;
  localparam logic [SLICE_W-1:0] SLICE_LIMIT_RST = 8'd10;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SLEEP = 2'd1;
  localparam logic [1:0] REQ_EXIT  = 2'd2;
  localparam logic [1:0] REQ_FORK  = 2'd3;

  typedef enum logic [1:0] {
    ST_DEAD     = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_BLOCKED  = 2'd3
  } entry_st_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SLEEP_W-1:0] sleep_ticks;
  } in_word_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] running_index;
    logic                 fork_ok;
    logic [OUT_IDX_W-1:0] fork_index;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic mark_cur;
    logic idx_clr;
    logic idx_one;
    logic idx_inc;
    logic wake_wr;
    logic slice_upd;
    logic found_set;
    logic pick;
    logic fork_claim;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       idx_last;
    logic       search_hit;
    logic       dead_hit;
    logic       cur_running;
    logic       slice_keep;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

### sv/tick_process_scheduler.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tick_process_scheduler
// Time-slice task scheduler with sleep, exit and fork requests.
// ---------------------------------------------------------------------------
//  port group  dir   handshake          word
//  in_*        in    in_valid/in_stall  in_word_t (req_type, sleep_ticks)
//  out_*       out   out_valid/out_stall out_word_t (running_index, fork_ok,
//                                       fork_index)
//  cfg_*       in    cfg_valid/cfg_ready slice limit, 8 bit
//
//  One request at a time. Tick, sleep and exit run the wake sweep (read
//  then write of the sleep RAM per entry) and, unless the running entry
//  keeps its slice, the runnable search (one entry a cycle). Fork scans
//  one entry a cycle.
//  A new word is taken while the last result still waits at the output.
//  Synchronous reset; no clearing pass. cfg_ready is always high.
// ---------------------------------------------------------------------------
module tick_process_scheduler import tps_pkg::*; #(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_word_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_word_t               out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [SLICE_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tps_dp #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### sv/tps_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tps_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module tps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/tps_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tps_ctrl
// Sequencer: wake sweep, slice update, runnable search and fork scan.
// ---------------------------------------------------------------------------
module tps_ctrl import tps_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_WRD,
    S_WWR,
    S_SRD,
    S_SWR,
    S_SRCH,
    S_PICK,
    S_FORK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        cmd.idx_clr = 1'b1;
        if (sts.req_type == REQ_FORK) begin
          state_nxt = S_FORK;
        end else begin
          cmd.mark_cur = 1'b1;
          state_nxt    = S_WRD;
        end
      end
      S_WRD: begin
        state_nxt = S_WWR;
      end
      S_WWR: begin
        cmd.wake_wr = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_SRD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_WRD;
        end
      end
      S_SRD: begin
        if (sts.cur_running) begin
          state_nxt = S_SWR;
        end else begin
          cmd.idx_one = 1'b1;
          state_nxt   = S_SRCH;
        end
      end
      S_SWR: begin
        cmd.slice_upd = 1'b1;
        if (sts.slice_keep) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_one = 1'b1;
          state_nxt   = S_SRCH;
        end
      end
      S_SRCH: begin
        if (sts.search_hit) begin
          cmd.found_set = 1'b1;
          state_nxt     = S_PICK;
        end else if (sts.idx_last) begin
          state_nxt = S_PICK;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_DONE;
      end
      S_FORK: begin
        if (sts.dead_hit) begin
          cmd.fork_claim = 1'b1;
          state_nxt      = S_DONE;
        end else if (sts.idx_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_out_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !sts.out_free) |=> (state_r == S_DONE))
    else $error("result dropped while output word pending");

endmodule

`default_nettype wire

### sv/tps_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tps_dp
// Task table, sleep and slice counters, search registers and output word.
// ---------------------------------------------------------------------------
module tps_dp import tps_pkg::*; #(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire in_word_t           in_data,
  input  wire logic               cfg_we,
  input  wire logic [SLICE_W-1:0] cfg_data,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_word_t               out_data
);

  localparam int IW = $clog2(NUM_ENTRIES);

  entry_st_t          status_r [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] slice_vld_r;
  logic [IW-1:0]      idx_r, cur_r, found_r, fork_idx_r;
  logic               found_vld_r, fork_ok_r;
  logic [1:0]         req_r;
  logic [SLEEP_W-1:0] ticks_r;
  logic [SLICE_W-1:0] limit_r;
  logic               out_valid_r;
  out_word_t          out_data_r;

  entry_st_t          st_idx, st_cur, st_pick;
  logic [IW-1:0]      pick_idx;
  logic [SLEEP_W-1:0] sleep_rdata, sleep_dec, sleep_wdata;
  logic [IW-1:0]      sleep_waddr, slice_waddr;
  logic               sleep_we, slice_we;
  logic [SLICE_W-1:0] slice_rdata, slice_cnt, slice_wdata;
  logic [NUM_ENTRIES-1:0] run_vec;

  assign st_idx   = status_r[idx_r];
  assign st_cur   = status_r[cur_r];
  assign st_pick  = status_r[found_r];
  assign pick_idx = found_vld_r ? found_r
                  : ((st_cur == ST_RUNNABLE) ? cur_r : '0);

  assign sleep_dec = sleep_rdata - SLEEP_W'(1);
  assign slice_cnt = (slice_vld_r[cur_r] ? slice_rdata : '0) + SLICE_W'(1);

  always_comb begin
    sleep_we    = 1'b0;
    sleep_waddr = idx_r;
    sleep_wdata = sleep_dec;
    if (cmd.mark_cur && req_r == REQ_SLEEP) begin
      sleep_we    = 1'b1;
      sleep_waddr = cur_r;
      sleep_wdata = ticks_r;
    end else if (cmd.wake_wr && st_idx == ST_BLOCKED) begin
      sleep_we = 1'b1;
    end
  end

  always_comb begin
    slice_we    = cmd.slice_upd | cmd.fork_claim;
    slice_waddr = cmd.fork_claim ? idx_r : cur_r;
    slice_wdata = (cmd.slice_upd && sts.slice_keep) ? slice_cnt : '0;
  end

  tps_ram #(.WIDTH(SLEEP_W), .DEPTH(NUM_ENTRIES)) u_sleep_ram (
    .clk   (clk),
    .we    (sleep_we),
    .waddr (sleep_waddr),
    .wdata (sleep_wdata),
    .raddr (idx_r),
    .rdata (sleep_rdata)
  );

  tps_ram #(.WIDTH(SLICE_W), .DEPTH(NUM_ENTRIES)) u_slice_ram (
    .clk   (clk),
    .we    (slice_we),
    .waddr (slice_waddr),
    .wdata (slice_wdata),
    .raddr (cur_r),
    .rdata (slice_rdata)
  );

  always_comb begin
    sts.req_type    = req_r;
    sts.idx_last    = (idx_r == IW'(NUM_ENTRIES - 1));
    sts.search_hit  = (st_idx == ST_RUNNABLE) && (idx_r != cur_r);
    sts.dead_hit    = (st_idx == ST_DEAD);
    sts.cur_running = (st_cur == ST_RUNNING);
    sts.slice_keep  = (slice_cnt < limit_r);
    sts.out_free    = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        status_r[i] <= (i == 0) ? ST_RUNNING : ST_DEAD;
      end
      slice_vld_r <= '0;
      cur_r       <= '0;
      limit_r     <= SLICE_LIMIT_RST;
      out_valid_r <= 1'b0;
      found_vld_r <= 1'b0;
      fork_ok_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (cmd.cap) begin
        found_vld_r <= 1'b0;
        fork_ok_r   <= 1'b0;
      end
      if (cmd.mark_cur) begin
        if (req_r == REQ_SLEEP) begin
          status_r[cur_r] <= ST_BLOCKED;
        end else if (req_r == REQ_EXIT) begin
          status_r[cur_r] <= ST_DEAD;
        end
      end
      if (cmd.wake_wr && st_idx == ST_BLOCKED && sleep_dec == '0) begin
        status_r[idx_r] <= ST_RUNNABLE;
      end
      if (slice_we) begin
        slice_vld_r[slice_waddr] <= 1'b1;
      end
      if (cmd.slice_upd && !sts.slice_keep) begin
        status_r[cur_r] <= ST_RUNNABLE;
      end
      if (cmd.found_set) begin
        found_vld_r <= 1'b1;
      end
      if (cmd.pick) begin
        status_r[pick_idx] <= ST_RUNNING;
        cur_r              <= pick_idx;
      end
      if (cmd.fork_claim) begin
        status_r[idx_r] <= ST_RUNNABLE;
        fork_ok_r       <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r      <= in_data.req_type;
      ticks_r    <= in_data.sleep_ticks;
      fork_idx_r <= '0;
    end
    if (cmd.fork_claim) begin
      fork_idx_r <= idx_r;
    end
    if (cmd.found_set) begin
      found_r <= idx_r;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_one) begin
      idx_r <= IW'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IW'(1);
    end
    if (cmd.out_load) begin
      out_data_r.running_index <= OUT_IDX_W'(cur_r);
      out_data_r.fork_ok       <= fork_ok_r;
      out_data_r.fork_index    <= OUT_IDX_W'(fork_idx_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_run
    assign run_vec[g] = (status_r[g] == ST_RUNNING);
  end

  a_one_running: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(run_vec) <= 1)
    else $error("more than one task running");

  a_pick_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick |=> (status_r[cur_r] == ST_RUNNING))
    else $error("chosen task not marked running");

  a_found_runnable: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick && found_vld_r |-> (st_pick == ST_RUNNABLE))
    else $error("search result no longer runnable");

  a_fork_claim: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fork_claim |=> fork_ok_r && (status_r[fork_idx_r] == ST_RUNNABLE))
    else $error("fork claim not recorded");

endmodule

`default_nettype wire

### test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Testbench for tick_process_scheduler. A task-table tracker predicts the
// running entry and the fork outcome of every accepted request word and
// checks each result word in order. A directed opening covers table fill,
// a refused fork, sleep wrap, immediate wake, fallback to entry 0 and a
// lowered slice limit. Random phases then run under several slice limits,
// with random idling on both sides and one long output hold.
// ---------------------------------------------------------------------------
module tb import tps_pkg::*; ();

  localparam int NE      = DEF_NUM_ENTRIES;
  localparam int LAT_MAX = NE * 3 + 5;

  class sched_tracker;
    entry_st_t          status [NE];
    logic [SLEEP_W-1:0] sleep_left [NE];
    logic [SLICE_W-1:0] slice_used [NE];
    logic [SLICE_W-1:0] slice_limit;
    int unsigned        cur;
    out_word_t          expected_q [$];
    int                 n_err = 0;
    int                 n_req [4] = '{0, 0, 0, 0};
    int                 n_fork_fail = 0;
    int                 n_preempt = 0;
    int                 n_fallback = 0;

    function new();
      slice_limit = SLICE_LIMIT_RST;
      cur = 0;
      foreach (status[i]) begin
        status[i]     = ST_DEAD;
        sleep_left[i] = '0;
        slice_used[i] = '0;
      end
      status[0] = ST_RUNNING;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void run_tick();
      int unsigned pick;
      pick = cur;
      for (int i = 0; i < NE; i++) begin
        if (status[i] == ST_BLOCKED) begin
          sleep_left[i] = sleep_left[i] - 1'b1;
          if (sleep_left[i] == '0) status[i] = ST_RUNNABLE;
        end
      end
      if (status[cur] == ST_RUNNING) begin
        slice_used[cur] = slice_used[cur] + 1'b1;
        if (slice_used[cur] < slice_limit) return;
        slice_used[cur] = '0;
        status[cur]     = ST_RUNNABLE;
        n_preempt++;
      end
      for (int i = 1; i < NE; i++) begin
        if (status[i] == ST_RUNNABLE && i != cur) begin
          pick = i;
          break;
        end
      end
      if (status[pick] != ST_RUNNABLE) begin
        pick = 0;
        n_fallback++;
      end
      status[pick] = ST_RUNNING;
      cur = pick;
    endfunction

    function void accept_request(in_word_t w);
      out_word_t r;
      r = '0;
      n_req[w.req_type]++;
      case (w.req_type)
        REQ_TICK: run_tick();
        REQ_SLEEP: begin
          status[cur]     = ST_BLOCKED;
          sleep_left[cur] = w.sleep_ticks;
          run_tick();
        end
        REQ_EXIT: begin
          status[cur] = ST_DEAD;
          run_tick();
        end
        default: begin
          for (int i = 0; i < NE; i++) begin
            if (status[i] == ST_DEAD) begin
              status[i]     = ST_RUNNABLE;
              slice_used[i] = '0;
              sleep_left[i] = '0;
              r.fork_ok     = 1'b1;
              r.fork_index  = OUT_IDX_W'(i);
              break;
            end
          end
          if (!r.fork_ok) n_fork_fail++;
        end
      endcase
      r.running_index = OUT_IDX_W'(cur);
      expected_q.push_back(r);
    endfunction

    function void check_outcome(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        $error("result word %h with nothing outstanding", got);
        n_err++;
        return;
      end
      want = expected_q.pop_front();
      if (got.running_index !== want.running_index) begin
        $error("running_index: expected %0d, got %0d", want.running_index, got.running_index);
        n_err++;
      end
      if (got.fork_ok !== want.fork_ok) begin
        $error("fork_ok: expected %0d, got %0d", want.fork_ok, got.fork_ok);
        n_err++;
      end
      if (got.fork_index !== want.fork_index) begin
        $error("fork_index: expected %0d, got %0d", want.fork_index, got.fork_index);
        n_err++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_word_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_word_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [SLICE_W-1:0] cfg_data;

  sched_tracker sb = new();
  bit           quiet_in;
  bit           quiet_out;
  bit           holding;
  int unsigned  out_hold;

  tick_process_scheduler #(.NUM_ENTRIES(NE)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("FAIL");
    $finish;
  end

  function automatic in_word_t mk(logic [1:0] kind, logic [SLEEP_W-1:0] ticks);
    in_word_t w;
    w.req_type    = kind;
    w.sleep_ticks = ticks;
    return w;
  endfunction

  // mostly short sleeps so that sleepers wake within the run
  function automatic in_word_t random_request();
    in_word_t    w;
    int unsigned roll;
    roll          = $urandom_range(0, 99);
    w.sleep_ticks = SLEEP_W'($urandom_range(0, 65535));
    if (roll < 45) begin
      w.req_type = REQ_TICK;
    end else if (roll < 65) begin
      w.req_type = REQ_SLEEP;
      roll = $urandom_range(0, 63);
      if (roll < 52) w.sleep_ticks = SLEEP_W'($urandom_range(1, 24));
      else if (roll < 63) w.sleep_ticks = SLEEP_W'($urandom_range(25, 600));
    end else if (roll < 77) begin
      w.req_type = REQ_EXIT;
    end else begin
      w.req_type = REQ_FORK;
    end
    return w;
  endfunction

  task automatic drive_word(in_word_t w);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) quiet_in = !quiet_in;
    gap = (quiet_in || holding) ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.accept_request(w);
  endtask

  task automatic finish_phase();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_slice_limit(logic [SLICE_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.slice_limit = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int unsigned gap;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (out_hold != 0) begin
        holding   = 1'b1;
        out_stall = 1'b1;
        repeat (out_hold) @(negedge clk);
        out_hold = 0;
        holding  = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) quiet_out = !quiet_out;
      gap = quiet_out ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_outcome(out_data);
    end
  end

  initial begin
    logic [SLICE_W-1:0] limits [5];
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    limits    = '{8'd255, 8'd1, 8'd0, 8'd2, 8'd0};
    limits[4] = SLICE_W'($urandom_range(3, 40));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill the table, then one refused fork
    drive_word(mk(REQ_TICK, 16'h5a5a));
    repeat (NE) drive_word(mk(REQ_FORK, 16'ha5a5));
    drive_word(mk(REQ_EXIT, 16'h0000));
    drive_word(mk(REQ_SLEEP, 16'hffff));
    drive_word(mk(REQ_SLEEP, 16'h0000));
    drive_word(mk(REQ_SLEEP, 16'h0001));
    // exits until nothing is runnable: entry 0 taken back while dead
    repeat (5) drive_word(mk(REQ_EXIT, 16'hffff));
    // entry 0 taken back while blocked
    drive_word(mk(REQ_SLEEP, 16'h0002));
    drive_word(mk(REQ_FORK, 16'h0000));
    repeat (3) drive_word(mk(REQ_TICK, 16'h0000));
    finish_phase();
    // count already past the lowered limit
    set_slice_limit(8'd3);
    drive_word(mk(REQ_TICK, 16'hffff));

    foreach (limits[p]) begin
      finish_phase();
      set_slice_limit(limits[p]);
      if (p == 1) out_hold = 300;
      repeat (400) drive_word(random_request());
    end
    finish_phase();
    repeat (LAT_MAX + 16) @(posedge clk);

    $display("Ran %0d requests: %0d ticks, %0d sleeps, %0d exits, %0d forks (%0d refused).",
             sb.n_req[0] + sb.n_req[1] + sb.n_req[2] + sb.n_req[3], sb.n_req[REQ_TICK],
             sb.n_req[REQ_SLEEP], sb.n_req[REQ_EXIT], sb.n_req[REQ_FORK], sb.n_fork_fail);
    $display("%0d slice expiries, %0d returns to entry 0; slice limits 10 3 255 1 0 2 %0d.",
             sb.n_preempt, sb.n_fallback, limits[4]);
    if (sb.n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
